// ----- sv/lfu_cache_store_macros.svh -----
// Assertion macros for the LFU store top level.
`ifndef LFU_CACHE_STORE_MACROS_SVH
`define LFU_CACHE_STORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LFU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfu_cache_store: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LFU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfu_cache_store: next-cycle check failed");

`endif

// ----- sv/lfu_pkg.sv -----
// Package: constants and shared types for the LFU key/value store.
package lfu_pkg;

   localparam int LFU_ENTRIES    = 16;
   localparam int LFU_COUNT_BITS = 16;
   localparam int LFU_CAP_W      = 5;
   localparam int LFU_DATA_W     = 32;

   localparam logic [LFU_CAP_W-1:0]  LFU_CAP_RESET = 5'd16;
   localparam logic [LFU_DATA_W-1:0] LFU_MISS_DATA = 32'hFFFF_FFFF;

   // request kinds
   localparam logic LFU_OP_GET = 1'b0;
   localparam logic LFU_OP_PUT = 1'b1;

   // verdict of the compare unit on one scanned entry
   typedef struct packed {
      logic match;   // valid entry holding the request key
      logic better;  // valid entry that beats the current victim
      logic free;    // empty slot
   } lfu_cmp_res_type;

endpackage

// ----- sv/lfu_if.sv -----
// Request and response channel interfaces for the LFU store.
interface lfu_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] key;
   logic [31:0] value;

   modport source (output valid, output req_type, output key, output value, input ready);
   modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] read_data;
   logic        evicted;
   logic [31:0] evicted_key;

   modport source (output valid, output hit, output read_data, output evicted,
                   output evicted_key, input ready);
   modport sink   (input valid, input hit, input read_data, input evicted,
                   input evicted_key, output ready);
endinterface

// ----- sv/lfu_cache_store.sv -----
// Top level: LFU key/value store with a scanning sequencer.
//
//  channel   port       direction  contents
//  request   req_bus    in         req_type, key, value
//  response  rsp_bus    out        hit, read_data, evicted, evicted_key
//  control   csr_*      in         capacity (5 bits, write only)
//
// A request is taken only in idle. The scan reads one entry per cycle through the single
// read port, compares the last entry in the cycle after its read, then writes back: the
// response becomes valid and ready returns in the same cycle, so a new request is taken
// only once the last one is through write-back. The response sits in an output register;
// the next request is taken while it waits, but write-back stalls until it has been taken.
// Reset is synchronous: it clears the valid flags, occupancy and access clock and returns
// capacity to 16.
module lfu_cache_store
   import lfu_pkg::*;
#(
   parameter int ENTRIES    = LFU_ENTRIES,
   parameter int COUNT_BITS = LFU_COUNT_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   lfu_req_if.sink              req_bus,
   lfu_rsp_if.source            rsp_bus,
   input  logic                 csr_we,
   input  logic [LFU_CAP_W-1:0] csr_wdata
);

`include "lfu_cache_store_macros.svh"

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0]      CNT_LAST  = CNT_W'(ENTRIES);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE} state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic                  op_ff, op_in;
   logic [LFU_DATA_W-1:0] key_ff, key_in;
   logic [LFU_DATA_W-1:0] value_ff, value_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      found_idx_ff, found_idx_in;
   logic [LFU_DATA_W-1:0] found_value_ff, found_value_in;
   logic [COUNT_BITS-1:0] found_count_ff, found_count_in;
   logic                  vic_have_ff, vic_have_in;
   logic [IDX_W-1:0]      vic_idx_ff, vic_idx_in;
   logic [COUNT_BITS-1:0] vic_count_ff, vic_count_in;
   logic [LFU_DATA_W-1:0] vic_age_ff, vic_age_in;
   logic [LFU_DATA_W-1:0] vic_key_ff, vic_key_in;
   logic                  free_have_ff, free_have_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [LFU_DATA_W-1:0] clock_ff, clock_in;
   logic [LFU_CAP_W-1:0]  cap_ff, cap_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [LFU_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_ev_ff, rsp_ev_in;
   logic [LFU_DATA_W-1:0] rsp_ev_key_ff, rsp_ev_key_in;

   // memory and compare unit wiring
   logic                  rd_en;
   logic                  rd_valid;
   logic [LFU_DATA_W-1:0] rd_key, rd_value, rd_stamp;
   logic [COUNT_BITS-1:0] rd_count;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [LFU_DATA_W-1:0] wr_value;
   logic [COUNT_BITS-1:0] wr_count;
   lfu_cmp_res_type       cmp_res;
   logic [LFU_DATA_W-1:0] cmp_age;

   // write-back decisions
   logic                  accept;
   logic                  go_write;
   logic [31:0]           eff_cap;
   logic                  full;
   logic                  evict;
   logic                  insert;

   lfu_store #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (cnt_ff[IDX_W-1:0]),
      .rd_valid (rd_valid),
      .rd_key   (rd_key),
      .rd_value (rd_value),
      .rd_count (rd_count),
      .rd_stamp (rd_stamp),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (key_ff),
      .wr_value (wr_value),
      .wr_count (wr_count),
      .wr_stamp (clock_ff)
   );

   lfu_cmp #(
      .COUNT_BITS (COUNT_BITS)
   ) u_cmp (
      .ent_valid    (rd_valid),
      .ent_key      (rd_key),
      .ent_count    (rd_count),
      .ent_stamp    (rd_stamp),
      .req_key      (key_ff),
      .access_clock (clock_ff),
      .best_have    (vic_have_ff),
      .best_count   (vic_count_ff),
      .best_age     (vic_age_ff),
      .res          (cmp_res),
      .age          (cmp_age)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign accept              = req_bus.valid && req_bus.ready;
   assign rd_en               = (state_ff == ST_SCAN) && (cnt_ff != CNT_LAST);
   assign go_write            = (state_ff == ST_WRITE) && (!rsp_vld_ff || rsp_bus.ready);

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.hit         = rsp_hit_ff;
   assign rsp_bus.read_data   = rsp_data_ff;
   assign rsp_bus.evicted     = rsp_ev_ff;
   assign rsp_bus.evicted_key = rsp_ev_key_ff;

   // clamp capacity into 1..ENTRIES
   always_comb begin
      eff_cap = 32'(cap_ff);
      if (eff_cap == 32'd0) begin
         eff_cap = 32'd1;
      end
      if (eff_cap > 32'(ENTRIES)) begin
         eff_cap = 32'(ENTRIES);
      end
   end

   assign full   = (32'(occ_ff) >= eff_cap);
   assign evict  = (op_ff == LFU_OP_PUT) && !found_ff && full && vic_have_ff;
   assign insert = (op_ff == LFU_OP_PUT) && !found_ff && (evict || free_have_ff);

   // write port: hit update or new entry
   always_comb begin
      wr_en    = go_write && (found_ff || insert);
      wr_addr  = found_ff ? found_idx_ff : (evict ? vic_idx_ff : free_idx_ff);
      wr_value = value_ff;
      wr_count = COUNT_BITS'(1);
      if (found_ff) begin
         wr_value = (op_ff == LFU_OP_PUT) ? value_ff : found_value_ff;
         wr_count = (found_count_ff == COUNT_MAX) ? found_count_ff
                                                  : found_count_ff + COUNT_BITS'(1);
      end
   end

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      cmp_vld_in     = rd_en;
      cmp_idx_in     = cnt_ff[IDX_W-1:0];
      op_in          = op_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_value_in = found_value_ff;
      found_count_in = found_count_ff;
      vic_have_in    = vic_have_ff;
      vic_idx_in     = vic_idx_ff;
      vic_count_in   = vic_count_ff;
      vic_age_in     = vic_age_ff;
      vic_key_in     = vic_key_ff;
      free_have_in   = free_have_ff;
      free_idx_in    = free_idx_ff;
      occ_in         = occ_ff;
      clock_in       = clock_ff;
      cap_in         = csr_we ? csr_wdata : cap_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp_bus.ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_ev_in      = rsp_ev_ff;
      rsp_ev_key_in  = rsp_ev_key_ff;

      // fold in the entry read last cycle
      if (cmp_vld_ff) begin
         if (cmp_res.match && !found_ff) begin
            found_in       = 1'b1;
            found_idx_in   = cmp_idx_ff;
            found_value_in = rd_value;
            found_count_in = rd_count;
         end
         if (cmp_res.better) begin
            vic_have_in  = 1'b1;
            vic_idx_in   = cmp_idx_ff;
            vic_count_in = rd_count;
            vic_age_in   = cmp_age;
            vic_key_in   = rd_key;
         end
         if (cmp_res.free && !free_have_ff) begin
            free_have_in = 1'b1;
            free_idx_in  = cmp_idx_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in     = ST_SCAN;
               cnt_in       = '0;
               op_in        = req_bus.req_type;
               key_in       = req_bus.key;
               value_in     = req_bus.value;
               found_in     = 1'b0;
               vic_have_in  = 1'b0;
               free_have_in = 1'b0;
            end
         end
         ST_SCAN: begin
            // advance the read address; the last entry compares at the end count
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_WRITE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_WRITE: begin
            if (go_write) begin
               state_in      = ST_IDLE;
               rsp_vld_in    = 1'b1;
               rsp_hit_in    = found_ff;
               rsp_ev_in     = evict;
               rsp_ev_key_in = evict ? vic_key_ff : '0;
               if (op_ff == LFU_OP_GET) begin
                  rsp_data_in = found_ff ? found_value_ff : LFU_MISS_DATA;
               end else begin
                  rsp_data_in = '0;
               end
               if (found_ff || insert) begin
                  clock_in = clock_ff + 32'd1;
               end
               if (insert && !evict) begin
                  occ_in = occ_ff + OCC_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmp_vld_ff <= 1'b0;
         occ_ff     <= '0;
         clock_ff   <= '0;
         cap_ff     <= LFU_CAP_RESET;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         occ_ff     <= occ_in;
         clock_ff   <= clock_in;
         cap_ff     <= cap_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      cnt_ff         <= cnt_in;
      cmp_idx_ff     <= cmp_idx_in;
      op_ff          <= op_in;
      key_ff         <= key_in;
      value_ff       <= value_in;
      found_ff       <= found_in;
      found_idx_ff   <= found_idx_in;
      found_value_ff <= found_value_in;
      found_count_ff <= found_count_in;
      vic_have_ff    <= vic_have_in;
      vic_idx_ff     <= vic_idx_in;
      vic_count_ff   <= vic_count_in;
      vic_age_ff     <= vic_age_in;
      vic_key_ff     <= vic_key_in;
      free_have_ff   <= free_have_in;
      free_idx_ff    <= free_idx_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_ev_key_ff  <= rsp_ev_key_in;
   end

   // checks
   `LFU_ASSERT_NEXT(a_accept_starts_scan, clock, reset, accept, state_ff == ST_SCAN && cnt_ff == '0)
   `LFU_ASSERT_NOW(a_rsp_from_write, clock, reset, $rose(rsp_vld_ff), $past(state_ff == ST_WRITE))
   `LFU_ASSERT_NOW(a_evict_is_miss, clock, reset, rsp_vld_ff && rsp_ev_ff, !rsp_hit_ff)
   `LFU_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, 32'(occ_ff) <= 32'(ENTRIES))

endmodule

// ----- sv/lfu_store.sv -----
// Entry memory with per-entry valid flags and a registered read port.
module lfu_store
   import lfu_pkg::*;
#(
   parameter int ENTRIES    = LFU_ENTRIES,
   parameter int COUNT_BITS = LFU_COUNT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(ENTRIES)-1:0]    rd_addr,
   output logic                          rd_valid,
   output logic [LFU_DATA_W-1:0]         rd_key,
   output logic [LFU_DATA_W-1:0]         rd_value,
   output logic [COUNT_BITS-1:0]         rd_count,
   output logic [LFU_DATA_W-1:0]         rd_stamp,
   input  logic                          wr_en,
   input  logic [$clog2(ENTRIES)-1:0]    wr_addr,
   input  logic [LFU_DATA_W-1:0]         wr_key,
   input  logic [LFU_DATA_W-1:0]         wr_value,
   input  logic [COUNT_BITS-1:0]         wr_count,
   input  logic [LFU_DATA_W-1:0]         wr_stamp
);

   localparam int WORD_W = 3*LFU_DATA_W + COUNT_BITS;

   logic [WORD_W-1:0] mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [WORD_W-1:0]  rd_word_ff;
   logic               rd_valid_ff;

   // write port: every write leaves a live entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_key, wr_value, wr_count, wr_stamp};
      end
   end

   // valid flags, cleared at once by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign {rd_key, rd_value, rd_count, rd_stamp} = rd_word_ff;

endmodule

// ----- sv/lfu_cmp.sv -----
// Shared compare unit: key match, free slot and victim ranking for one entry.
module lfu_cmp
   import lfu_pkg::*;
#(
   parameter int COUNT_BITS = LFU_COUNT_BITS
) (
   input  logic                  ent_valid,
   input  logic [LFU_DATA_W-1:0] ent_key,
   input  logic [COUNT_BITS-1:0] ent_count,
   input  logic [LFU_DATA_W-1:0] ent_stamp,
   input  logic [LFU_DATA_W-1:0] req_key,
   input  logic [LFU_DATA_W-1:0] access_clock,
   input  logic                  best_have,
   input  logic [COUNT_BITS-1:0] best_count,
   input  logic [LFU_DATA_W-1:0] best_age,
   output lfu_cmp_res_type       res,
   output logic [LFU_DATA_W-1:0] age
);

   // age wraps modulo 2^32; greater age is older
   assign age = access_clock - ent_stamp;

   // lower count wins, then older; equal keeps the earlier slot
   always_comb begin
      res.match  = ent_valid && (ent_key == req_key);
      res.free   = !ent_valid;
      res.better = ent_valid && (!best_have || (ent_count < best_count) ||
                   ((ent_count == best_count) && (age > best_age)));
   end

endmodule
